/* src/byte_pattern_search_unit_defines.svh */
// Assertion helpers shared by the RTL files.
// All checks are clocked on clk and held off while arst_n is low.
`ifndef BYTE_PATTERN_SEARCH_UNIT_DEFINES_SVH
`define BYTE_PATTERN_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication.
`define BPS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/bps_pkg.sv */
`default_nettype none

package bps_pkg;

	localparam int MAX_PATTERN_BYTES_DEF = 16;
	localparam int MAX_BUFFER_BYTES_DEF  = 65536;

	// Pattern bytes held in the configuration registers
	localparam int PATTERN_SLOTS = 16;
	localparam int LEN_W         = 5;
	localparam int INDEX_W       = 16;
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_ADDR_W    = 3;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_PATTERN_LOW      = 3'd0,
		REG_PATTERN_HIGH     = 3'd1,
		REG_PATTERN_LENGTH   = 3'd2,
		REG_CASE_INSENSITIVE = 3'd3,
		REG_START_INDEX      = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [PATTERN_SLOTS-1:0][7:0] pattern;
		logic [LEN_W-1:0]              length;
		logic                          case_insensitive;
		logic [INDEX_W-1:0]            start_index;
	} cfg_t;

	typedef struct packed {
		logic               found;
		logic [INDEX_W-1:0] match_index;
	} result_t;

	// ASCII upper case to lower case when folding is on
	function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic ci);
		if (ci && (b inside {[8'h41:8'h5A]}))
			return b + 8'h20;
		return b;
	endfunction

endpackage

`default_nettype wire

/* src/byte_pattern_search_unit.sv */
// A result goes from the input register through the window compare into the output register.
// One byte per cycle via the combinational compare, unless a result finds the output full.
// The input register takes a new byte while a result waits in the output register.
// Reset (arst_n low, async): configuration registers, buffer position and match flag
// return to zero, both stages empty; the window holds no reset value and needs none.
`default_nettype none

`include "byte_pattern_search_unit_defines.svh"

module byte_pattern_search_unit #(
	parameter int MAX_PATTERN_BYTES = bps_pkg::MAX_PATTERN_BYTES_DEF,
	parameter int MAX_BUFFER_BYTES  = bps_pkg::MAX_BUFFER_BYTES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [bps_pkg::CFG_ADDR_W-1:0] cfg_index,
	input  wire logic [bps_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [7:0]                     data_byte,
	input  wire logic                           last,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                found,
	output logic [bps_pkg::INDEX_W-1:0]         match_index
);
	import bps_pkg::*;

	cfg_t    cfg;
	result_t result;

	logic       in_valid_s1;
	logic [7:0] data_byte_s1;
	logic       last_s1;
	logic       emit, advance, res_ready;

	bps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// byte leaves the input register unless its result has nowhere to go
	assign advance  = in_valid_s1 && (!emit || res_ready);
	assign in_ready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_valid_s1 <= 1'b0;
		else if (in_ready)
			in_valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_byte_s1 <= data_byte;
			last_s1      <= last;
		end
	end

	bps_match_core #(
		.MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
		.MAX_BUFFER_BYTES  (MAX_BUFFER_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.advance   (advance),
		.data_byte (data_byte_s1),
		.last      (last_s1),
		.emit      (emit),
		.result    (result)
	);

	bps_result_reg u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load_valid  (advance && emit),
		.load_ready  (res_ready),
		.load_data   (result),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.match_index (match_index)
	);

	`BPS_ASSERT_NOW(a_stall_only_on_result, in_valid_s1 && !advance, emit && !res_ready, "stall without pending result")
	`BPS_ASSERT_NEXT(a_result_loaded, advance && emit, out_valid, "result lost")

endmodule

`default_nettype wire

/* src/bps_cfg_regs.sv */
`default_nettype none

module bps_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [bps_pkg::CFG_ADDR_W-1:0] cfg_index,
	input  wire logic [bps_pkg::CFG_DATA_W-1:0] cfg_data,
	output bps_pkg::cfg_t                       cfg
);
	import bps_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PATTERN_LOW:      cfg_q.pattern[7:0]  <= cfg_data;
				REG_PATTERN_HIGH:     cfg_q.pattern[15:8] <= cfg_data;
				REG_PATTERN_LENGTH:   cfg_q.length <= cfg_data[LEN_W-1:0];
				REG_CASE_INSENSITIVE: cfg_q.case_insensitive <= cfg_data[0];
				REG_START_INDEX:      cfg_q.start_index <= cfg_data[INDEX_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* src/bps_match_core.sv */
`default_nettype none

`include "byte_pattern_search_unit_defines.svh"

module bps_match_core #(
	parameter int MAX_PATTERN_BYTES = bps_pkg::MAX_PATTERN_BYTES_DEF,
	parameter int MAX_BUFFER_BYTES  = bps_pkg::MAX_BUFFER_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  bps_pkg::cfg_t   cfg,
	input  wire logic       advance,
	input  wire logic [7:0] data_byte,
	input  wire logic       last,
	output logic            emit,
	output bps_pkg::result_t result
);
	import bps_pkg::*;

	localparam int POS_W = $clog2(MAX_BUFFER_BYTES + 1);
	localparam int CNT_W = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int CMP_W = (POS_W > INDEX_W) ? POS_W : INDEX_W;
	localparam int CW    = (CNT_W > LEN_W) ? CNT_W : LEN_W;

	logic [MAX_PATTERN_BYTES-1:0][7:0] win_q, win_n;
	logic [POS_W-1:0]                  pos_q;
	logic [CNT_W-1:0]                  cnt_q, cnt_n;
	logic                              matched_q;

	logic                         active, counting, len_ok, match;
	logic [MAX_PATTERN_BYTES-1:0] eq;
	logic [CMP_W-1:0]             idx_w;

	// newest byte sits in entry 0
	always_comb begin
		win_n[0] = data_byte;
		for (int i = 1; i < MAX_PATTERN_BYTES; i++)
			win_n[i] = win_q[i-1];
	end

	assign active   = !matched_q && (pos_q < POS_W'(MAX_BUFFER_BYTES));
	assign counting = (CMP_W'(pos_q) >= CMP_W'(cfg.start_index)) &&
	                  (cnt_q < CNT_W'(MAX_PATTERN_BYTES));
	assign cnt_n    = counting ? cnt_q + 1'b1 : cnt_q;
	assign len_ok   = (cfg.length != '0) &&
	                  (CW'(cfg.length) <= CW'(MAX_PATTERN_BYTES)) &&
	                  (CW'(cnt_n) >= CW'(cfg.length));

	// window entry j lines up with pattern byte length-1-j
	always_comb begin
		int         k;
		logic [7:0] pb;
		for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
			k  = int'(cfg.length) - 1 - j;
			pb = 8'h00;
			if (k >= 0 && k < PATTERN_SLOTS)
				pb = cfg.pattern[k[3:0]];
			eq[j] = (j >= int'(cfg.length)) ||
			        (fold_byte(win_n[j], cfg.case_insensitive) ==
			         fold_byte(pb, cfg.case_insensitive));
		end
	end

	assign match = active && len_ok && (&eq);
	assign emit  = match || (last && !matched_q);
	assign idx_w = CMP_W'(pos_q) + CMP_W'(1) - CMP_W'(cfg.length);

	assign result.found       = match;
	assign result.match_index = match ? idx_w[INDEX_W-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			cnt_q     <= '0;
			matched_q <= 1'b0;
		end else if (advance) begin
			if (last) begin
				pos_q     <= '0;
				cnt_q     <= '0;
				matched_q <= 1'b0;
			end else if (active) begin
				pos_q     <= pos_q + 1'b1;
				cnt_q     <= cnt_n;
				matched_q <= match;
			end
		end
	end

	// only counted bytes are compared, so the window needs no clear
	always_ff @(posedge clk) begin
		if (advance && active)
			win_q <= win_n;
	end

	`BPS_ASSERT_NEXT(a_match_latches, advance && match && !last, matched_q, "match not latched")
	`BPS_ASSERT_NOW(a_single_match, matched_q, !match, "second match in one buffer")
	`BPS_ASSERT_NOW(a_count_bound, 1'b1, cnt_q <= CNT_W'(MAX_PATTERN_BYTES), "count overrun")

endmodule

`default_nettype wire

/* src/bps_result_reg.sv */
`default_nettype none

module bps_result_reg (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load_valid,
	output logic             load_ready,
	input  bps_pkg::result_t load_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             found,
	output logic [bps_pkg::INDEX_W-1:0] match_index
);
	import bps_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign load_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load_ready)
			valid_q <= load_valid;
	end

	always_ff @(posedge clk) begin
		if (load_valid && load_ready)
			data_q <= load_data;
	end

	assign out_valid   = valid_q;
	assign found       = data_q.found;
	assign match_index = data_q.match_index;

endmodule

`default_nettype wire
